/* hdl/video_test_pattern_generator_top_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the test pattern generator
// Shared concurrent-assertion forms, clocked and gated by the active-low reset.
// ----------------------------------------------------------------------------
`ifndef VIDEO_TEST_PATTERN_GENERATOR_TOP_ASSERT_SVH
`define VIDEO_TEST_PATTERN_GENERATOR_TOP_ASSERT_SVH

// Same-cycle implication.
`define VTPG_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vtpg assertion failed");

// Next-cycle implication.
`define VTPG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vtpg assertion failed");

`endif

/* hdl/vtpg_pkg.sv */
// ----------------------------------------------------------------------------
// vtpg_pkg
// Types, codes, palette and color tables of the test pattern generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vtpg_pkg;

    typedef enum logic [2:0] {
        CFG_PATTERN = 3'd0,
        CFG_WIDTH   = 3'd1,
        CFG_HEIGHT  = 3'd2,
        CFG_HICOLOR = 3'd3,
        CFG_SOLID   = 3'd4,
        CFG_STEP    = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        PAT_BARS    = 2'd0,
        PAT_GRID    = 2'd1,
        PAT_SOLID   = 2'd2,
        PAT_RAINBOW = 2'd3
    } t_pattern;

    localparam logic [7:0] PAL_WHITE   = 8'd0;
    localparam logic [7:0] PAL_YELLOW  = 8'd1;
    localparam logic [7:0] PAL_CYAN    = 8'd2;
    localparam logic [7:0] PAL_GREEN   = 8'd3;
    localparam logic [7:0] PAL_MAGENTA = 8'd4;
    localparam logic [7:0] PAL_RED     = 8'd5;
    localparam logic [7:0] PAL_BLUE    = 8'd6;
    localparam logic [7:0] PAL_BLACK   = 8'd7;
    localparam logic [7:0] PAL_GRAY    = 8'd8;
    localparam logic [7:0] PAL_LGRAY   = 8'd9;

    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int DIM_W      = 10;
    localparam int PIX_W      = 15;

    localparam logic [DIM_W-1:0] WIDTH_RESET  = 10'd320;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 10'd240;
    localparam logic [31:0]      STEP_RESET   = 32'd218;

    // Scan state of the pixel being produced, handed from counters to color logic.
    typedef struct packed {
        logic [DIM_W-1:0] column;
        logic [DIM_W-1:0] row;
        logic             line_end;
        logic             frame_end;
        logic [7:0]       pal_bar;
        logic             grid_white;
        logic [31:0]      sweep;
    } t_scan_info;

    // Palette entry packed as G-R-B 555, top 5 bits of each channel.
    function automatic logic [PIX_W-1:0] color_word(input logic [7:0] idx);
        logic [4:0] r;
        logic [4:0] g;
        logic [4:0] b;
        r = 5'd0;
        g = 5'd0;
        b = 5'd0;
        unique case (idx)
            PAL_WHITE:   begin r = 5'd31; g = 5'd31; b = 5'd31; end
            PAL_YELLOW:  begin r = 5'd31; g = 5'd31; end
            PAL_CYAN:    begin g = 5'd31; b = 5'd31; end
            PAL_GREEN:   begin g = 5'd31; end
            PAL_MAGENTA: begin r = 5'd31; b = 5'd31; end
            PAL_RED:     begin r = 5'd31; end
            PAL_BLUE:    begin b = 5'd31; end
            PAL_GRAY:    begin r = 5'd16; g = 5'd16; b = 5'd16; end
            PAL_LGRAY:   begin r = 5'd24; g = 5'd24; b = 5'd24; end
            default:     begin r = 5'd0; g = 5'd0; b = 5'd0; end
        endcase
        return {g, r, b};
    endfunction

    // Solid color choice to palette index; unused choices give black.
    function automatic logic [7:0] solid_index(input logic [2:0] choice);
        logic [7:0] idx;
        unique case (choice)
            3'd0:    idx = PAL_WHITE;
            3'd1:    idx = PAL_RED;
            3'd2:    idx = PAL_GREEN;
            3'd3:    idx = PAL_BLUE;
            default: idx = PAL_BLACK;
        endcase
        return idx;
    endfunction

endpackage

/* hdl/vtpg_in_if.sv */
// ----------------------------------------------------------------------------
// vtpg_in_if
// Pixel slot request channel: valid/ready with the frame restart flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface vtpg_in_if;
    logic valid;
    logic ready;
    logic frame_start;

    modport source (output valid, output frame_start, input ready);
    modport sink   (input valid, input frame_start, output ready);
endinterface

/* hdl/vtpg_out_if.sv */
// ----------------------------------------------------------------------------
// vtpg_out_if
// Pixel result channel: valid/ready with pixel value, coordinates and flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface vtpg_out_if;
    logic        valid;
    logic        ready;
    logic [14:0] pixel_value;
    logic [9:0]  column;
    logic [9:0]  row;
    logic        line_end;
    logic        frame_end;

    modport source (output valid, output pixel_value, output column, output row,
                    output line_end, output frame_end, input ready);
    modport sink   (input valid, input pixel_value, input column, input row,
                    input line_end, input frame_end, output ready);
endinterface

/* hdl/vtpg_scan.sv */
// ----------------------------------------------------------------------------
// vtpg_scan
// Raster counters: column, row, bar, grid phase and sweep accumulator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vtpg_scan #(
    parameter int GRID_STEP = 16,
    parameter int BAR_COUNT = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_advance,
    input  logic                  i_frame_start,
    input  logic [9:0]            i_frame_width,
    input  logic [9:0]            i_frame_height,
    input  logic [31:0]           i_rainbow_step,
    output vtpg_pkg::t_scan_info  o_info
);

    localparam int BI_W   = $clog2(BAR_COUNT);
    localparam int GP_W   = $clog2(GRID_STEP);
    localparam int PROD_W = 11 + BI_W + 1;

    logic [9:0]      r_col,    n_col;
    logic [9:0]      r_row,    n_row;
    logic [BI_W-1:0] r_bar,    n_bar;
    logic [9:0]      r_bpos,   n_bpos;
    logic [GP_W-1:0] r_col_ph, n_col_ph;
    logic [GP_W-1:0] r_row_ph, n_row_ph;
    logic [31:0]     r_sweep,  n_sweep;

    logic [9:0]        cur_col;
    logic [9:0]        cur_row;
    logic [BI_W-1:0]   cur_bar;
    logic [9:0]        cur_bpos;
    logic [GP_W-1:0]   cur_col_ph;
    logic [GP_W-1:0]   cur_row_ph;
    logic [31:0]       cur_sweep;
    logic [10:0]       col_inc;
    logic [10:0]       row_inc;
    logic              lend;
    logic              fend;
    logic              bar_narrow;
    logic              bar_step;
    logic [PROD_W-1:0] bar_limit;
    logic [PROD_W-1:0] width_ext;

    // Frame restart takes effect on this very pixel.
    assign cur_col    = i_frame_start ? '0 : r_col;
    assign cur_row    = i_frame_start ? '0 : r_row;
    assign cur_bar    = i_frame_start ? '0 : r_bar;
    assign cur_bpos   = i_frame_start ? '0 : r_bpos;
    assign cur_col_ph = i_frame_start ? '0 : r_col_ph;
    assign cur_row_ph = i_frame_start ? '0 : r_row_ph;
    assign cur_sweep  = i_frame_start ? '0 : r_sweep;

    assign col_inc = {1'b0, cur_col} + 11'd1;
    assign row_inc = {1'b0, cur_row} + 11'd1;
    assign lend    = col_inc >= {1'b0, i_frame_width};
    assign fend    = lend && (row_inc >= {1'b0, i_frame_height});

    // Bar width is width / BAR_COUNT; compare against multiples instead of dividing.
    assign width_ext  = PROD_W'(i_frame_width);
    assign bar_limit  = PROD_W'({1'b0, cur_bpos} + 11'd2) * PROD_W'(BAR_COUNT);
    assign bar_narrow = width_ext < PROD_W'(BAR_COUNT);
    assign bar_step   = (cur_bar != BI_W'(BAR_COUNT - 1)) && (width_ext < bar_limit);

    always_comb begin
        o_info.column     = cur_col;
        o_info.row        = cur_row;
        o_info.line_end   = lend;
        o_info.frame_end  = fend;
        o_info.pal_bar    = bar_narrow ? 8'(BAR_COUNT - 1) : 8'(cur_bar);
        o_info.grid_white = (cur_col_ph == '0) || (cur_row_ph == '0) ||
                            (col_inc == {1'b0, i_frame_width}) ||
                            (row_inc == {1'b0, i_frame_height});
        o_info.sweep      = cur_sweep;
    end

    always_comb begin
        n_col    = cur_col;
        n_row    = cur_row;
        n_bar    = cur_bar;
        n_bpos   = cur_bpos;
        n_col_ph = cur_col_ph;
        n_row_ph = cur_row_ph;
        n_sweep  = fend ? 32'd0 : cur_sweep + i_rainbow_step;
        if (lend) begin
            n_col    = '0;
            n_bar    = '0;
            n_bpos   = '0;
            n_col_ph = '0;
            if (fend) begin
                n_row    = '0;
                n_row_ph = '0;
            end else begin
                n_row    = row_inc[9:0];
                n_row_ph = (cur_row_ph == GP_W'(GRID_STEP - 1)) ? '0 : cur_row_ph + GP_W'(1);
            end
        end else begin
            n_col    = col_inc[9:0];
            n_col_ph = (cur_col_ph == GP_W'(GRID_STEP - 1)) ? '0 : cur_col_ph + GP_W'(1);
            if (bar_step) begin
                n_bar  = cur_bar + BI_W'(1);
                n_bpos = '0;
            end else begin
                n_bpos = cur_bpos + 10'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_bar    <= '0;
            r_bpos   <= '0;
            r_col_ph <= '0;
            r_row_ph <= '0;
            r_sweep  <= '0;
        end else if (i_advance) begin
            r_col    <= n_col;
            r_row    <= n_row;
            r_bar    <= n_bar;
            r_bpos   <= n_bpos;
            r_col_ph <= n_col_ph;
            r_row_ph <= n_row_ph;
            r_sweep  <= n_sweep;
        end
    end

endmodule

/* hdl/vtpg_color.sv */
// ----------------------------------------------------------------------------
// vtpg_color
// Pattern select and pixel encoding: palette index, GRB555 word or rainbow sweep value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vtpg_color (
    input  vtpg_pkg::t_scan_info  i_info,
    input  vtpg_pkg::t_pattern    i_pattern,
    input  logic                  i_high_color,
    input  logic [2:0]            i_solid_choice,
    output logic [14:0]           o_pixel_value
);

    logic [7:0] pal_idx;

    always_comb begin
        pal_idx       = vtpg_pkg::PAL_BLACK;
        o_pixel_value = '0;
        unique case (i_pattern)
            vtpg_pkg::PAT_BARS: begin
                pal_idx = i_info.pal_bar;
            end
            vtpg_pkg::PAT_GRID: begin
                pal_idx = i_info.grid_white ? vtpg_pkg::PAL_WHITE : vtpg_pkg::PAL_BLACK;
            end
            vtpg_pkg::PAT_SOLID: begin
                pal_idx = vtpg_pkg::solid_index(i_solid_choice);
            end
            default: begin
                pal_idx = vtpg_pkg::PAL_BLACK;
            end
        endcase

        if (i_pattern == vtpg_pkg::PAT_RAINBOW) begin
            // Integer part of the 16.16 sweep.
            o_pixel_value = i_high_color ? i_info.sweep[30:16] : {7'd0, i_info.sweep[23:16]};
        end else begin
            o_pixel_value = i_high_color ? vtpg_pkg::color_word(pal_idx) : {7'd0, pal_idx};
        end
    end

endmodule

/* hdl/video_test_pattern_generator_top.sv */
// ----------------------------------------------------------------------------
// video_test_pattern_generator_top
// An accepted pixel slot is encoded combinationally and loaded into the output register.
// Throughput: one pixel per cycle while the sink is ready; the output register frees as it is taken.
// The per-pixel path is the bar-limit constant multiply and the 32-bit sweep add.
// Reset (synchronous, active low) clears the scan counters and the output valid
// and loads the configuration defaults: bars, 320 x 240, palette mode, step 218.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "video_test_pattern_generator_top_assert.svh"

module video_test_pattern_generator_top #(
    parameter int GRID_STEP = 16,
    parameter int BAR_COUNT = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [31:0]  i_cfg_data,
    vtpg_in_if.sink      i_in,
    vtpg_out_if.source   o_out
);

    // Configuration registers, to be written only while the block is idle; the block does not enforce this.
    vtpg_pkg::t_pattern r_pattern;
    logic [9:0]         r_frame_width;
    logic [9:0]         r_frame_height;
    logic               r_high_color;
    logic [2:0]         r_solid_choice;
    logic [31:0]        r_rainbow_step;

    // Output register: holds one finished pixel until the sink takes it.
    logic        r_out_valid;
    logic [14:0] r_out_pixel;
    logic [9:0]  r_out_column;
    logic [9:0]  r_out_row;
    logic        r_out_line_end;
    logic        r_out_frame_end;

    logic                 in_acc;
    logic                 in_ready;
    logic [14:0]          pixel_value;
    vtpg_pkg::t_scan_info scan_info;

    // Take a new slot whenever the output register is empty or being drained.
    assign in_ready   = !r_out_valid || o_out.ready;
    assign i_in.ready = in_ready;
    assign in_acc     = i_in.valid && in_ready;

    // Decode configuration writes; drop writes to unused indexes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern      <= vtpg_pkg::PAT_BARS;
            r_frame_width  <= vtpg_pkg::WIDTH_RESET;
            r_frame_height <= vtpg_pkg::HEIGHT_RESET;
            r_high_color   <= 1'b0;
            r_solid_choice <= 3'd0;
            r_rainbow_step <= vtpg_pkg::STEP_RESET;
        end else if (i_cfg_we) begin
            unique case (vtpg_pkg::t_cfg_idx'(i_cfg_idx))
                vtpg_pkg::CFG_PATTERN: r_pattern      <= vtpg_pkg::t_pattern'(i_cfg_data[1:0]);
                vtpg_pkg::CFG_WIDTH:   r_frame_width  <= i_cfg_data[9:0];
                vtpg_pkg::CFG_HEIGHT:  r_frame_height <= i_cfg_data[9:0];
                vtpg_pkg::CFG_HICOLOR: r_high_color   <= i_cfg_data[0];
                vtpg_pkg::CFG_SOLID:   r_solid_choice <= i_cfg_data[2:0];
                vtpg_pkg::CFG_STEP:    r_rainbow_step <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Raster counters advance once per accepted slot.
    vtpg_scan #(
        .GRID_STEP (GRID_STEP),
        .BAR_COUNT (BAR_COUNT)
    ) u_scan (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_advance      (in_acc),
        .i_frame_start  (i_in.frame_start),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .i_rainbow_step (r_rainbow_step),
        .o_info         (scan_info)
    );

    // Pick the pattern and encode the pixel.
    vtpg_color u_color (
        .i_info         (scan_info),
        .i_pattern      (r_pattern),
        .i_high_color   (r_high_color),
        .i_solid_choice (r_solid_choice),
        .o_pixel_value  (pixel_value)
    );

    // Valid tracks transactions; payload loads only on accept.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out_pixel     <= pixel_value;
            r_out_column    <= scan_info.column;
            r_out_row       <= scan_info.row;
            r_out_line_end  <= scan_info.line_end;
            r_out_frame_end <= scan_info.frame_end;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.pixel_value = r_out_pixel;
    assign o_out.column      = r_out_column;
    assign o_out.row         = r_out_row;
    assign o_out.line_end    = r_out_line_end;
    assign o_out.frame_end   = r_out_frame_end;

    // A frame end is always a line end.
    `VTPG_ASSERT_NOW(a_fend_is_lend, i_clk, i_rst_n, r_out_valid && r_out_frame_end, r_out_line_end)
    // An accepted transaction always lands in the output register.
    `VTPG_ASSERT_NEXT(a_acc_fills_out, i_clk, i_rst_n, in_acc, r_out_valid)
    // A restarted scan reports the origin.
    `VTPG_ASSERT_NEXT(a_restart_origin, i_clk, i_rst_n, in_acc && i_in.frame_start, r_out_column == 10'd0 && r_out_row == 10'd0)
    // After a line end the next slot starts at column zero.
    `VTPG_ASSERT_NEXT(a_line_wrap, i_clk, i_rst_n, in_acc && scan_info.line_end, scan_info.column == 10'd0)

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the test pattern generator: pixel slots go in
// through a queue-fed driver, results are checked in order against a
// raster predictor that mirrors the counters, bars, grid, solid and sweep.
// ----------------------------------------------------------------------------

module tb;

    localparam int GRID_STEP      = 16;
    localparam int BAR_COUNT      = 8;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int MAX_REPORTS    = 10;
    localparam int RANDOM_SLOTS   = 1100;

    // Register indexes past the last real register; writes must be ignored.
    localparam logic [2:0] CFG_SPARE_LO = 3'd6;
    localparam logic [2:0] CFG_SPARE_HI = 3'd7;

    // Solid color choices as the register encodes them.
    localparam logic [2:0] SOLID_WHITE = 3'd0;
    localparam logic [2:0] SOLID_RED   = 3'd1;
    localparam logic [2:0] SOLID_GREEN = 3'd2;
    localparam logic [2:0] SOLID_BLUE  = 3'd3;
    localparam logic [2:0] SOLID_BLACK = 3'd4;
    localparam logic [2:0] SOLID_BAD   = 3'd7;

    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle;

    typedef struct packed {
        logic [14:0] value;
        logic [9:0]  column;
        logic [9:0]  row;
        logic        line_end;
        logic        frame_end;
    } t_pixel;

    typedef struct {
        logic restart;
        bit   drain_first;
    } t_slot;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;

    vtpg_in_if  pix_req ();
    vtpg_out_if pix_out ();

    video_test_pattern_generator_top #(
        .GRID_STEP (GRID_STEP),
        .BAR_COUNT (BAR_COUNT)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (pix_req),
        .o_out      (pix_out)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Shadow copy of the configuration registers.
    vtpg_pkg::t_pattern sh_pattern;
    logic [9:0]         sh_width;
    logic [9:0]         sh_height;
    logic               sh_hicolor;
    logic [2:0]         sh_solid;
    logic [31:0]        sh_step;

    // Shadow raster state.
    logic [9:0]  scan_col;
    logic [9:0]  scan_row;
    logic [2:0]  bar_idx;
    logic [9:0]  bar_pos;
    logic [31:0] sweep_acc;

    t_slot  slot_queue[$];     // pixel slots not yet offered
    t_pixel pixels_due[$];     // predicted pixels still owed by the block

    int  send_idle_pct;
    int  stall_pct;
    bit  slot_taken;
    int  mismatch_count;
    int  pixels_checked;
    int  lines_seen;
    int  frames_seen;
    int  restarts_sent;
    int  settings_used;
    int  quiet_cycles;

    // 8-bit RGB of each palette entry; anything past the palette is black.
    function automatic logic [23:0] palette_rgb(input logic [7:0] idx);
        case (idx)
            vtpg_pkg::PAL_WHITE:   return 24'hFFFFFF;
            vtpg_pkg::PAL_YELLOW:  return 24'hFFFF00;
            vtpg_pkg::PAL_CYAN:    return 24'h00FFFF;
            vtpg_pkg::PAL_GREEN:   return 24'h00FF00;
            vtpg_pkg::PAL_MAGENTA: return 24'hFF00FF;
            vtpg_pkg::PAL_RED:     return 24'hFF0000;
            vtpg_pkg::PAL_BLUE:    return 24'h0000FF;
            vtpg_pkg::PAL_GRAY:    return 24'h808080;
            vtpg_pkg::PAL_LGRAY:   return 24'hC0C0C0;
            default:               return 24'h000000;
        endcase
    endfunction

    // Palette index as sent on the wire: raw in 8-bit mode, G-R-B 555 otherwise.
    function automatic logic [14:0] palette_out(input logic [7:0] idx, input logic hicolor);
        logic [23:0] rgb;
        rgb = palette_rgb(idx);
        if (hicolor)
            return {rgb[15:11], rgb[23:19], rgb[7:3]};
        return {7'd0, idx};
    endfunction

    function automatic logic [7:0] solid_palette_entry(input logic [2:0] choice);
        case (choice)
            SOLID_WHITE: return vtpg_pkg::PAL_WHITE;
            SOLID_RED:   return vtpg_pkg::PAL_RED;
            SOLID_GREEN: return vtpg_pkg::PAL_GREEN;
            SOLID_BLUE:  return vtpg_pkg::PAL_BLUE;
            default:     return vtpg_pkg::PAL_BLACK;
        endcase
    endfunction

    task automatic load_power_on();
        sh_pattern = vtpg_pkg::PAT_BARS;
        sh_width   = vtpg_pkg::WIDTH_RESET;
        sh_height  = vtpg_pkg::HEIGHT_RESET;
        sh_hicolor = 1'b0;
        sh_solid   = SOLID_WHITE;
        sh_step    = vtpg_pkg::STEP_RESET;
        scan_col   = '0;
        scan_row   = '0;
        bar_idx    = '0;
        bar_pos    = '0;
        sweep_acc  = '0;
    endtask

    // Produce the pixel for one accepted slot and advance the raster.
    task automatic predict_pixel(input logic restart, output t_pixel px);
        int unsigned width_u;
        int unsigned height_u;
        int unsigned col_u;
        int unsigned row_u;
        int unsigned bar_w;
        logic        lend;
        logic        fend;
        logic        white;
        if (restart) begin
            scan_col  = '0;
            scan_row  = '0;
            bar_idx   = '0;
            bar_pos   = '0;
            sweep_acc = '0;
        end
        width_u  = sh_width;
        height_u = sh_height;
        col_u    = scan_col;
        row_u    = scan_row;
        bar_w    = width_u / BAR_COUNT;
        // A zero size compares like one: every pixel closes the line.
        lend  = (col_u + 1) >= width_u;
        fend  = lend && (row_u + 1) >= height_u;
        white = (col_u % GRID_STEP) == 0 || (row_u % GRID_STEP) == 0 ||
                col_u + 1 == width_u || row_u + 1 == height_u;
        case (sh_pattern)
            vtpg_pkg::PAT_BARS:
                px.value = palette_out((bar_w == 0) ? 8'(BAR_COUNT - 1) : 8'(bar_idx),
                                       sh_hicolor);
            vtpg_pkg::PAT_GRID:
                px.value = palette_out(white ? vtpg_pkg::PAL_WHITE : vtpg_pkg::PAL_BLACK,
                                       sh_hicolor);
            vtpg_pkg::PAT_SOLID:
                px.value = palette_out(solid_palette_entry(sh_solid), sh_hicolor);
            default:
                px.value = sh_hicolor ? sweep_acc[30:16] : {7'd0, sweep_acc[23:16]};
        endcase
        px.column    = scan_col;
        px.row       = scan_row;
        px.line_end  = lend;
        px.frame_end = fend;

        if (lend) begin
            scan_col = '0;
            bar_idx  = '0;
            bar_pos  = '0;
            scan_row = fend ? 10'd0 : scan_row + 10'd1;
        end else begin
            scan_col = scan_col + 10'd1;
            if (bar_idx < BAR_COUNT - 1 && bar_pos + 1 >= bar_w) begin
                bar_idx = bar_idx + 3'd1;
                bar_pos = '0;
            end else begin
                bar_pos = bar_pos + 10'd1;
            end
        end
        // The sweep runs under every pattern and restarts after each frame.
        sweep_acc = fend ? 32'd0 : sweep_acc + sh_step;
    endtask

    // ------------------------------------------------------------------
    // Driver: offer the next pending slot at the falling edge once the
    // previous transaction is gone; hold valid while the slot waits.
    // The result side stalls at random in the same process.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!pix_req.valid || slot_taken) begin
            if (slot_queue.size() != 0 && $urandom_range(99) >= send_idle_pct &&
                !(slot_queue[0].drain_first && pixels_due.size() != 0)) begin
                pix_req.valid       <= 1'b1;
                pix_req.frame_start <= slot_queue[0].restart;
                void'(slot_queue.pop_front());
            end else begin
                pix_req.valid <= 1'b0;
            end
        end
        pix_out.ready <= ($urandom_range(99) >= stall_pct);
    end

    // ------------------------------------------------------------------
    // Monitor: check results first, then track register writes, then
    // predict the pixel for a slot taken at this edge. A result never
    // belongs to a slot taken at the same edge, so this order is safe.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_pixel got;
        t_pixel want;
        t_pixel next_px;
        slot_taken = 1'b0;
        if (i_rst_n) begin
            if (pix_out.valid && pix_out.ready) begin
                got = {pix_out.pixel_value, pix_out.column, pix_out.row,
                       pix_out.line_end, pix_out.frame_end};
                if (pixels_due.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: unexpected pixel %h at (%0d,%0d), nothing pending",
                                 $time, got.value, got.column, got.row);
                end else begin
                    want = pixels_due.pop_front();
                    pixels_checked++;
                    if (want.line_end)
                        lines_seen++;
                    if (want.frame_end)
                        frames_seen++;
                    if (got.value !== want.value || got.column !== want.column ||
                        got.row !== want.row || got.line_end !== want.line_end ||
                        got.frame_end !== want.frame_end) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS) begin
                            $write("%0t: pixel mismatch: expected %h (%0d,%0d) le=%b fe=%b,",
                                   $time, want.value, want.column, want.row, want.line_end,
                                   want.frame_end);
                            $display(" got %h (%0d,%0d) le=%b fe=%b", got.value, got.column,
                                     got.row, got.line_end, got.frame_end);
                        end
                    end
                end
            end

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    vtpg_pkg::CFG_PATTERN: sh_pattern = vtpg_pkg::t_pattern'(i_cfg_data[1:0]);
                    vtpg_pkg::CFG_WIDTH:   sh_width   = i_cfg_data[9:0];
                    vtpg_pkg::CFG_HEIGHT:  sh_height  = i_cfg_data[9:0];
                    vtpg_pkg::CFG_HICOLOR: sh_hicolor = i_cfg_data[0];
                    vtpg_pkg::CFG_SOLID:   sh_solid   = i_cfg_data[2:0];
                    vtpg_pkg::CFG_STEP:    sh_step    = i_cfg_data;
                    default:               ;
                endcase
            end

            if (pix_req.valid && pix_req.ready) begin
                slot_taken = 1'b1;
                if (pix_req.frame_start)
                    restarts_sent++;
                predict_pixel(pix_req.frame_start, next_px);
                pixels_due.push_back(next_px);
            end
        end
    end

    // Watchdog: end the run if no transaction moves for too long.
    always @(posedge i_clk) begin
        if ((pix_req.valid && pix_req.ready) || (pix_out.valid && pix_out.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", quiet_cycles);
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
    endtask

    // Write the registers selected in the mask, then drop the write enable.
    task automatic program_frame(input vtpg_pkg::t_pattern pat, input logic [9:0] w,
                                 input logic [9:0] h, input logic hi, input logic [2:0] solid,
                                 input logic [31:0] step, input logic [5:0] which);
        if (which[vtpg_pkg::CFG_PATTERN])
            write_reg(vtpg_pkg::CFG_PATTERN, {30'd0, pat});
        if (which[vtpg_pkg::CFG_WIDTH])
            write_reg(vtpg_pkg::CFG_WIDTH, {22'd0, w});
        if (which[vtpg_pkg::CFG_HEIGHT])
            write_reg(vtpg_pkg::CFG_HEIGHT, {22'd0, h});
        if (which[vtpg_pkg::CFG_HICOLOR])
            write_reg(vtpg_pkg::CFG_HICOLOR, {31'd0, hi});
        if (which[vtpg_pkg::CFG_SOLID])
            write_reg(vtpg_pkg::CFG_SOLID, {29'd0, solid});
        if (which[vtpg_pkg::CFG_STEP])
            write_reg(vtpg_pkg::CFG_STEP, step);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Queue a run of slots under one idling mode and wait until the block
    // has drained. Longer runs get one slot that waits for a full drain.
    task automatic run_slots(input int count, input bit restart_first, input int noise_pct,
                             input t_idle mode);
        t_slot s;
        int    drain_at;
        case (mode)
            IDLE_NONE:     begin send_idle_pct = 0;  stall_pct = 0;  end
            IDLE_SENDER:   begin send_idle_pct = 84; stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  stall_pct = 84; end
            default:       begin send_idle_pct = 32; stall_pct = 32; end
        endcase
        drain_at = (count > 8) ? int'($urandom_range(1, count - 1)) : -1;
        for (int k = 0; k < count; k++) begin
            s.restart     = (k == 0) ? restart_first : ($urandom_range(99) < noise_pct);
            s.drain_first = (k == drain_at);
            slot_queue.push_back(s);
        end
        while (slot_queue.size() != 0 || pixels_due.size() != 0 || pix_req.valid)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int                 random_slots;
        int                 phase;
        int                 count;
        int unsigned        pick;
        vtpg_pkg::t_pattern pat;
        logic [9:0]         w;
        logic [9:0]         h;
        logic [31:0]        step;
        logic [5:0]         which;

        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_idx           = '0;
        i_cfg_data          = '0;
        pix_req.valid       = 1'b0;
        pix_req.frame_start = 1'b0;
        pix_out.ready       = 1'b0;
        send_idle_pct       = 0;
        stall_pct           = 0;
        slot_taken          = 1'b0;
        mismatch_count      = 0;
        pixels_checked      = 0;
        lines_seen          = 0;
        frames_seen         = 0;
        restarts_sent       = 0;
        settings_used       = 1;
        quiet_cycles        = 0;
        load_power_on();

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Power-on defaults: bars at 320 x 240 in palette mode.
        run_slots(4, 1'b1, 0, IDLE_NONE);

        // One-line frame of eight single-pixel bars in 555 mode; frame end wraps.
        program_frame(vtpg_pkg::PAT_BARS, 10'd8, 10'd1, 1'b1, SOLID_WHITE,
                      vtpg_pkg::STEP_RESET, 6'h3F);
        run_slots(8, 1'b1, 0, IDLE_NONE);

        // Zero width and height act as one: every pixel ends line and frame.
        program_frame(vtpg_pkg::PAT_GRID, 10'd0, 10'd0, 1'b0, SOLID_BLACK, 32'd0, 6'h3F);
        run_slots(3, 1'b0, 0, IDLE_NONE);

        // Out-of-range solid choice shows black; spare indexes change nothing.
        write_reg(CFG_SPARE_LO, 32'hFFFF_FFFF);
        write_reg(CFG_SPARE_HI, 32'h0000_0001);
        program_frame(vtpg_pkg::PAT_SOLID, 10'd1023, 10'd1023, 1'b1, SOLID_BAD, 32'd0, 6'h3F);
        run_slots(2, 1'b1, 0, IDLE_NONE);

        // Sweep with an all-ones step wraps the accumulator on each step after the first.
        program_frame(vtpg_pkg::PAT_RAINBOW, 10'd1023, 10'd1023, 1'b0, SOLID_BLACK,
                      32'hFFFF_FFFF, 6'h3F);
        run_slots(4, 1'b1, 0, IDLE_NONE);

        // Random settings. The first one scans a wide line so the column
        // reaches its upper bits; the rest are mostly small so frames complete.
        random_slots = 0;
        phase        = 0;
        while (random_slots < RANDOM_SLOTS) begin
            pat  = vtpg_pkg::t_pattern'($urandom_range(0, 3));
            pick = $urandom_range(99);
            if (pick < 70)
                w = 10'($urandom_range(8, 40));
            else if (pick < 85)
                w = 10'($urandom_range(0, 7));
            else if (pick < 95)
                w = 10'($urandom_range(41, 200));
            else
                w = 10'($urandom_range(200, 1023));
            pick = $urandom_range(99);
            if (pick < 80)
                h = 10'($urandom_range(1, 6));
            else if (pick < 90)
                h = 10'd0;
            else
                h = 10'($urandom_range(7, 1023));
            pick = $urandom_range(99);
            if (pick < 30)
                step = $urandom_range(32'h0004_0000, 0);
            else if (pick < 45)
                step = 32'h8000_0000;
            else if (pick < 55)
                step = 32'hFFFF_FFFF;
            else if (pick < 65)
                step = 32'd0;
            else
                step = $urandom();
            which = 6'($urandom_range(1, 63));
            count = $urandom_range(40, 90);
            if (phase == 0) begin
                w     = 10'd1023;
                h     = 10'd2;
                which = 6'h3F;
                count = 520;
            end
            program_frame(pat, w, h, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), step,
                          which);
            // Most runs start a fresh frame; others pick up mid-frame under
            // the new sizes. A few stray restarts land inside each run.
            run_slots(count, ($urandom_range(99) < 60), 3, t_idle'(phase % 4));
            random_slots += count;
            phase++;
        end

        while (pixels_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pixels_due.size() != 0)
            mismatch_count += pixels_due.size();

        $display("Checked %0d pixels under %0d register settings: %0d line ends, %0d frame ends,",
                 pixels_checked, settings_used, lines_seen, frames_seen);
        $display("%0d frame restarts, %0d mismatches.", restarts_sent, mismatch_count);
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hdl
hdl/vtpg_pkg.sv
hdl/vtpg_in_if.sv
hdl/vtpg_out_if.sv
hdl/vtpg_scan.sv
hdl/vtpg_color.sv
hdl/video_test_pattern_generator_top.sv
tb/tb.sv
